@@ rtl/lkvc_pkg.sv @@
// ---------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the LRU key-value cache
// Table geometry, field widths, request codes and the entry layout used by
// the table memory and the control logic.
// ---------------------------------------------------------------------------
package lkvc_pkg;

	localparam int unsigned ENTRIES = 16;
	localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
	localparam int unsigned RANK_W  = IDX_W;

	localparam int unsigned KEY_W   = 32;
	localparam int unsigned VAL_W   = 32;
	localparam int unsigned CAP_W   = 5;
	localparam int unsigned CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam int unsigned APB_AW  = 3;
	localparam int unsigned APB_DW  = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;

	// Request codes.
	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_PUT = 1'b1;

	// Register indexes (byte address / 4).
	localparam logic [APB_AW-3:0] REG_CAPACITY = '0;

	// One table entry as held in memory.
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
		logic [RANK_W-1:0] rank;
	} entry_t;

endpackage

@@ rtl/lkvc_ram.sv @@
// ---------------------------------------------------------------------------
// lkvc_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered. Contents are
// undefined until written.
// ---------------------------------------------------------------------------
module lkvc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/lru_key_value_cache_top.sv @@
// ---------------------------------------------------------------------------
// lru_key_value_cache_top: fully associative key-value cache with LRU
// replacement.
//
// Requests arrive on the req channel (req_type, key, value) and are taken
// when req_valid and req_ready are both high. A get returns one transaction
// on the rsp channel (hit, read_value; read_value is all ones on a miss).
// A put returns nothing. Keys, values and recency ranks live in one table
// RAM; valid bits and the entry count sit in flip-flops.
// Each request first scans the whole table, one entry per cycle through the
// RAM read port. A get hit or any put then makes a second read-modify-write
// pass over the table to age ranks.
// One request is in work at a time; req_ready is high between requests.
// A finished response waits in an output register; if the receiver stalls,
// the next request is still taken, and only a second response waits.
// Reset and any write of the capacity register empty the table at once.
// Capacity is programmed over the APB port at address 0.
// ---------------------------------------------------------------------------
module lru_key_value_cache_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lkvc_pkg::APB_AW-1:0]         paddr,
	input  logic [lkvc_pkg::APB_DW-1:0]         pwdata,
	output logic [lkvc_pkg::APB_DW-1:0]         prdata,
	output logic                                pready,
	// requests
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic                                req_type,
	input  logic signed [lkvc_pkg::KEY_W-1:0]   key,
	input  logic signed [lkvc_pkg::VAL_W-1:0]   value,
	// responses
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic                                hit,
	output logic signed [lkvc_pkg::VAL_W-1:0]   read_value
);

	import lkvc_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_UPDATE = 3'd3;
	localparam logic [2:0] ST_RESULT = 3'd4;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   iss_cnt_q;
	logic               chk_s1;
	logic [IDX_W-1:0]   idx_s1;

	logic [CAP_W-1:0]   cap_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   count_q;

	logic               req_type_q;
	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   val_q;

	logic               hit_found_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [RANK_W-1:0]  hit_rank_q;
	logic [VAL_W-1:0]   hit_val_q;
	logic               free_found_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic               lru_any_q;
	logic [IDX_W-1:0]   lru_idx_q;
	logic [RANK_W-1:0]  lru_rank_q;

	logic [IDX_W-1:0]   tgt_q;
	logic [RANK_W-1:0]  thresh_q;
	logic               inc_all_q;

	logic               rsp_valid_q;
	logic               hit_q;
	logic [VAL_W-1:0]   read_value_q;

	logic               ren;
	logic [IDX_W-1:0]   raddr;
	entry_t             rdata;
	logic               we;
	entry_t             wdata;
	logic [VAL_W-1:0]   upd_val;
	logic               last_s1;
	logic               cfg_wr;
	logic               req_acc;
	logic               rsp_load;
	logic               evict;
	logic [CAP_W-1:0]   cap1;
	entry_t             cur;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_CAPACITY);
	assign prdata    = (paddr[APB_AW-1:2] == REG_CAPACITY) ?
	                   APB_DW'(cap_q) : '0;

	assign req_ready = (state_q == ST_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign hit       = hit_q;
	assign read_value = read_value_q;
	assign rsp_load  = (state_q == ST_RESULT) && (!rsp_valid_q || rsp_ready);

	// Capacity zero behaves as one; capacity above the table size is bounded
	// by the free-slot search, since a full table has no free slot.
	assign cap1  = (cap_q == '0) ? CAP_W'(1) : cap_q;
	assign evict = (CMP_W'(count_q) >= CMP_W'(cap1)) || !free_found_q;

	assign upd_val = (req_type_q == REQ_PUT) ? val_q : hit_val_q;
	assign cur     = rdata;

	// Both passes stream addresses 0..ENTRIES-1 through the read port.
	always_comb begin
		ren   = ((state_q == ST_SCAN) || (state_q == ST_UPDATE)) &&
		        (iss_cnt_q < CNT_W'(ENTRIES));
		raddr = iss_cnt_q[IDX_W-1:0];
	end

	assign last_s1 = chk_s1 && (idx_s1 == IDX_W'(ENTRIES - 1));

	// Write-back of the update pass: the entry read last cycle is written
	// while the next one is read, so the two addresses never meet.
	always_comb begin
		we    = 1'b0;
		wdata = cur;
		if ((state_q == ST_UPDATE) && chk_s1) begin
			if (idx_s1 == tgt_q) begin
				we          = 1'b1;
				wdata.key   = key_q;
				wdata.value = upd_val;
				wdata.rank  = '0;
			end else if (valid_q[idx_s1] && (inc_all_q || (cur.rank < thresh_q))) begin
				we         = 1'b1;
				wdata.rank = cur.rank + RANK_W'(1);
			end
		end
	end

	lkvc_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (idx_s1),
		.wdata (wdata),
		.re    (ren),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			iss_cnt_q    <= '0;
			chk_s1       <= 1'b0;
			cap_q        <= CAP_RESET;
			valid_q      <= '0;
			count_q      <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			lru_any_q    <= 1'b0;
			inc_all_q    <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			chk_s1 <= ren;
			if (ren) begin
				iss_cnt_q <= iss_cnt_q + CNT_W'(1);
			end
			if (rsp_valid_q && rsp_ready && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						lru_any_q    <= 1'b0;
						iss_cnt_q    <= '0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (chk_s1) begin
						if (valid_q[idx_s1] && (cur.key == key_q) && !hit_found_q) begin
							hit_found_q <= 1'b1;
						end
						if (!valid_q[idx_s1] && !free_found_q) begin
							free_found_q <= 1'b1;
						end
						if (valid_q[idx_s1] && (!lru_any_q || (cur.rank > lru_rank_q))) begin
							lru_any_q <= 1'b1;
						end
						if (last_s1) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					iss_cnt_q <= '0;
					if (hit_found_q) begin
						inc_all_q <= 1'b0;
						state_q   <= ST_UPDATE;
					end else if (req_type_q == REQ_GET) begin
						state_q <= ST_RESULT;
					end else begin
						// New key: every other valid entry ages by one.
						inc_all_q <= 1'b1;
						state_q   <= ST_UPDATE;
						if (!evict) begin
							valid_q[free_idx_q] <= 1'b1;
							count_q             <= count_q + CNT_W'(1);
						end
					end
				end
				ST_UPDATE: begin
					if (last_s1) begin
						state_q <= (req_type_q == REQ_GET) ? ST_RESULT : ST_IDLE;
					end
				end
				ST_RESULT: begin
					if (rsp_load) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_wr) begin
				cap_q   <= pwdata[CAP_W-1:0];
				valid_q <= '0;
				count_q <= '0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		idx_s1 <= raddr;
		if (req_acc) begin
			req_type_q <= req_type;
			key_q      <= key;
			val_q      <= value;
		end
		if ((state_q == ST_SCAN) && chk_s1) begin
			if (valid_q[idx_s1] && (cur.key == key_q) && !hit_found_q) begin
				hit_idx_q  <= idx_s1;
				hit_rank_q <= cur.rank;
				hit_val_q  <= cur.value;
			end
			if (!valid_q[idx_s1] && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
			if (valid_q[idx_s1] && (!lru_any_q || (cur.rank > lru_rank_q))) begin
				lru_idx_q  <= idx_s1;
				lru_rank_q <= cur.rank;
			end
		end
		if (state_q == ST_DECIDE) begin
			if (hit_found_q) begin
				tgt_q    <= hit_idx_q;
				thresh_q <= hit_rank_q;
			end else begin
				tgt_q    <= evict ? lru_idx_q : free_idx_q;
				thresh_q <= '0;
			end
		end
		if (rsp_load) begin
			hit_q        <= hit_found_q;
			read_value_q <= hit_found_q ? hit_val_q : MISS_VALUE;
		end
	end

	// The entry count always matches the number of valid entries.
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("entry count differs from number of valid entries");

	// The update pass never reads and writes the same entry in one cycle.
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(ren && we) |-> (raddr != idx_s1))
		else $error("table read and write address collide");

	// A response only appears after the block reached its result state.
	a_rsp_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_RESULT))
		else $error("response raised outside the result state");

	// A capacity write empties the store.
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (count_q == '0) && (valid_q == '0))
		else $error("store not empty after capacity write");

endmodule
